@@ src/vna_pkg.sv @@
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants for the vertex normal accumulator
// Beat structs, operation codes and fixed widths of the datapath.
// ----------------------------------------------------------------------------
package vna_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_BITS_DEF   = 16;

	localparam int OP_W    = 2;
	localparam int IDX_W   = 10;
	localparam int FIELD_W = 16;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_TRI  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	// accumulator and normaliser widths
	localparam int SUM_W   = 48;
	localparam int UNIT_W  = 16;
	localparam int R_W     = 31;  // magnitude width after range normalisation
	localparam int SQ_W    = 64;
	localparam int LEN_W   = 32;
	localparam int NUM_W   = 47;
	localparam int Q_W     = 15;
	localparam int FRAC_SH = 15;  // multiply by 32768

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [UNIT_W-1:0] UNIT_ONE = 16'sd16384;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic [IDX_W-1:0]          vertex_index;
		logic signed [FIELD_W-1:0] pos_x;
		logic signed [FIELD_W-1:0] pos_y;
		logic signed [FIELD_W-1:0] pos_z;
		logic [IDX_W-1:0]          corner_a;
		logic [IDX_W-1:0]          corner_b;
		logic [IDX_W-1:0]          corner_c;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         normal_vertex;
		logic signed [UNIT_W-1:0] unit_x;
		logic signed [UNIT_W-1:0] unit_y;
		logic signed [UNIT_W-1:0] unit_z;
		logic                     degenerate;
	} result_t;

endpackage

@@ src/vna_ram.sv @@
// ----------------------------------------------------------------------------
// vna_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/vna_cross.sv @@
// ----------------------------------------------------------------------------
// vna_cross: face cross product (A-B)x(B-C)
// One shared multiplier, six products in turn, then combine.
// ----------------------------------------------------------------------------
module vna_cross #(
	parameter int COORD_BITS = vna_pkg::COORD_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [3*COORD_BITS-1:0]                  pos_a,
	input  logic [3*COORD_BITS-1:0]                  pos_b,
	input  logic [3*COORD_BITS-1:0]                  pos_c,
	output logic                                     done,
	output logic signed [2*(COORD_BITS+1):0]         norm_x,
	output logic signed [2*(COORD_BITS+1):0]         norm_y,
	output logic signed [2*(COORD_BITS+1):0]         norm_z
);
	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;
	localparam int NW = PW + 1;

	logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	logic signed [DW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
	logic signed [DW-1:0] op_a, op_b;
	logic signed [PW-1:0] prod_s1;
	logic signed [NW-1:0] nx_q, ny_q, nz_q;
	logic [2:0]           cnt_q;
	logic                 busy_q;

	assign ax = pos_a[CB-1:0];
	assign ay = pos_a[2*CB-1:CB];
	assign az = pos_a[3*CB-1:2*CB];
	assign bx = pos_b[CB-1:0];
	assign by = pos_b[2*CB-1:CB];
	assign bz = pos_b[3*CB-1:2*CB];
	assign cx = pos_c[CB-1:0];
	assign cy = pos_c[2*CB-1:CB];
	assign cz = pos_c[3*CB-1:2*CB];

	// operand pairs: x = uy*vz - uz*vy, y = uz*vx - ux*vz, z = ux*vy - uy*vx
	always_comb begin
		case (cnt_q)
			3'd0: begin op_a = uy_q; op_b = vz_q; end
			3'd1: begin op_a = uz_q; op_b = vy_q; end
			3'd2: begin op_a = uz_q; op_b = vx_q; end
			3'd3: begin op_a = ux_q; op_b = vz_q; end
			3'd4: begin op_a = ux_q; op_b = vy_q; end
			3'd5: begin op_a = uy_q; op_b = vx_q; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd6) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ux_q <= DW'(ax) - DW'(bx);
			uy_q <= DW'(ay) - DW'(by);
			uz_q <= DW'(az) - DW'(bz);
			vx_q <= DW'(bx) - DW'(cx);
			vy_q <= DW'(by) - DW'(cy);
			vz_q <= DW'(bz) - DW'(cz);
		end else if (busy_q) begin
			prod_s1 <= PW'(op_a) * PW'(op_b);
			case (cnt_q)
				3'd1: nx_q <= NW'(prod_s1);
				3'd2: nx_q <= nx_q - NW'(prod_s1);
				3'd3: ny_q <= NW'(prod_s1);
				3'd4: ny_q <= ny_q - NW'(prod_s1);
				3'd5: nz_q <= NW'(prod_s1);
				3'd6: nz_q <= nz_q - NW'(prod_s1);
				default: ;
			endcase
		end
	end

	assign done   = busy_q && (cnt_q == 3'd6);
	assign norm_x = nx_q;
	assign norm_y = ny_q;
	assign norm_z = nz_q;
endmodule

@@ src/vna_norm.sv @@
// ----------------------------------------------------------------------------
// vna_norm: sum vector to Q1.14 unit vector
// Bit-serial range shift, square sum, integer square root and division.
// ----------------------------------------------------------------------------
module vna_norm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [vna_pkg::SUM_W-1:0]   sum_x,
	input  logic signed [vna_pkg::SUM_W-1:0]   sum_y,
	input  logic signed [vna_pkg::SUM_W-1:0]   sum_z,
	output logic                               done,
	output logic signed [vna_pkg::UNIT_W-1:0]  unit_x,
	output logic signed [vna_pkg::UNIT_W-1:0]  unit_y,
	output logic signed [vna_pkg::UNIT_W-1:0]  unit_z,
	output logic                               degenerate
);
	import vna_pkg::*;

	localparam logic [2:0] N_IDLE = 3'd0;
	localparam logic [2:0] N_DOWN = 3'd1;
	localparam logic [2:0] N_UP   = 3'd2;
	localparam logic [2:0] N_SQ   = 3'd3;
	localparam logic [2:0] N_ROOT = 3'd4;
	localparam logic [2:0] N_DSET = 3'd5;
	localparam logic [2:0] N_DIV  = 3'd6;
	localparam logic [2:0] N_DONE = 3'd7;

	logic [2:0]        state_q;
	logic [4:0]        cnt_q;
	logic [1:0]        comp_q;
	logic [SUM_W-1:0]  rx_q, ry_q, rz_q;
	logic              negx_q, negy_q, negz_q;
	logic [SUM_W-1:0]  m01, rmax;
	logic [R_W-1:0]    r_sel;
	logic              neg_sel;
	logic [2*R_W-1:0]  prod_s1;
	logic [SQ_W-1:0]   sq_q, rem_q, res_q, bit_q, trial;
	logic [NUM_W-1:0]  num_q, dsh_q;
	logic [Q_W-1:0]    q_q, q_next;
	logic              ge;
	logic signed [UNIT_W-1:0] uval;
	logic signed [UNIT_W-1:0] ux_q, uy_q, uz_q;
	logic              degen_q;

	assign m01  = (rx_q > ry_q) ? rx_q : ry_q;
	assign rmax = (m01 > rz_q) ? m01 : rz_q;

	// component select shared by square and divide phases
	always_comb begin
		case (state_q == N_SQ ? cnt_q[1:0] : comp_q)
			2'd0: begin r_sel = rx_q[R_W-1:0]; neg_sel = negx_q; end
			2'd1: begin r_sel = ry_q[R_W-1:0]; neg_sel = negy_q; end
			default: begin r_sel = rz_q[R_W-1:0]; neg_sel = negz_q; end
		endcase
	end

	assign trial  = res_q + bit_q;
	assign ge     = (num_q >= dsh_q);
	assign q_next = {q_q[Q_W-2:0], ge};
	assign uval   = neg_sel ? -UNIT_W'(q_next) : UNIT_W'(q_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
		end else begin
			case (state_q)
				N_IDLE: if (start) state_q <= N_DOWN;
				N_DOWN: begin
					if (rmax == '0) begin
						state_q <= N_DONE;
					end else if (rmax[SUM_W-1:R_W] == '0) begin
						state_q <= N_UP;
					end
				end
				N_UP: begin
					if (rmax[R_W-1]) begin
						state_q <= N_SQ;
						cnt_q   <= '0;
					end
				end
				N_SQ: begin
					if (cnt_q == 5'd3) begin
						state_q <= N_ROOT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				N_ROOT: begin
					if (cnt_q == 5'd31) begin
						state_q <= N_DSET;
						comp_q  <= '0;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				N_DSET: begin
					state_q <= N_DIV;
					cnt_q   <= '0;
				end
				N_DIV: begin
					if (cnt_q == 5'(Q_W - 1)) begin
						if (comp_q == 2'd2) begin
							state_q <= N_DONE;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= N_DSET;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				N_DONE: state_q <= N_IDLE;
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					rx_q    <= sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
					ry_q    <= sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
					rz_q    <= sum_z[SUM_W-1] ? SUM_W'(-sum_z) : SUM_W'(sum_z);
					negx_q  <= sum_x[SUM_W-1];
					negy_q  <= sum_y[SUM_W-1];
					negz_q  <= sum_z[SUM_W-1];
					degen_q <= 1'b0;
				end
			end
			N_DOWN: begin
				if (rmax == '0) begin
					degen_q <= 1'b1;
					ux_q    <= '0;
					uy_q    <= '0;
					uz_q    <= '0;
				end else if (rmax[SUM_W-1:R_W] != '0) begin
					rx_q <= rx_q >> 1;
					ry_q <= ry_q >> 1;
					rz_q <= rz_q >> 1;
				end
			end
			N_UP: begin
				if (!rmax[R_W-1]) begin
					rx_q <= rx_q << 1;
					ry_q <= ry_q << 1;
					rz_q <= rz_q << 1;
				end
				sq_q <= '0;
			end
			N_SQ: begin
				prod_s1 <= r_sel * r_sel;
				if (cnt_q != 5'd0) begin
					sq_q <= sq_q + SQ_W'(prod_s1);
				end
				if (cnt_q == 5'd3) begin
					rem_q <= sq_q + SQ_W'(prod_s1);
					res_q <= '0;
					bit_q <= SQ_W'(1) << (SQ_W - 2);
				end
			end
			N_ROOT: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DSET: begin
				// (r * 32768 + len) / (2 * len), quotient fits in Q_W bits
				num_q <= (NUM_W'(r_sel) << FRAC_SH) + NUM_W'(res_q[LEN_W-1:0]);
				dsh_q <= NUM_W'(res_q[LEN_W-1:0]) << Q_W;
				q_q   <= '0;
			end
			N_DIV: begin
				if (ge) begin
					num_q <= num_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				q_q   <= q_next;
				if (cnt_q == 5'(Q_W - 1)) begin
					case (comp_q)
						2'd0: ux_q <= uval;
						2'd1: uy_q <= uval;
						default: uz_q <= uval;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign done       = (state_q == N_DONE);
	assign unit_x     = ux_q;
	assign unit_y     = uy_q;
	assign unit_z     = uz_q;
	assign degenerate = degen_q;
endmodule

@@ src/vertex_normal_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_unit: area-weighted smooth vertex normals
// Position and normal-sum memories with read-modify-write accumulation.
// ----------------------------------------------------------------------------
// Load: the block stays idle, so the next beat is taken on the following cycle.
// Triangle: position reads for a, b and c, the cross product, then a sum RMW
//   per corner, serialised by the single read port of each memory and the shared multiplier.
// Read: paced by the bit-serial normaliser (range shift, sum of squares,
//   square root, then one division per component); a zero sum ends early.
// Reset clears control only; memories hold no reset value.
module vertex_normal_accumulator_unit #(
	parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  vna_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output vna_pkg::result_t  result
);
	import vna_pkg::*;

	localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int PW    = 3 * COORD_BITS;
	localparam int NW    = 2 * (COORD_BITS + 1) + 1;
	localparam int ADD_W = ((NW > SUM_W) ? NW : SUM_W) + 1;
	localparam int SW    = 3 * SUM_W;

	// top-level sequencer
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TPOS = 4'd1;  // read three corner positions
	localparam logic [3:0] S_TMUL = 4'd2;  // cross product in progress
	localparam logic [3:0] S_TRD  = 4'd3;  // read one corner sum
	localparam logic [3:0] S_TWR  = 4'd4;  // saturating add, write back
	localparam logic [3:0] S_RRD  = 4'd5;  // read sum for normalisation
	localparam logic [3:0] S_RSUM = 4'd6;  // sum data returned, start unit
	localparam logic [3:0] S_NORM = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;  // result waiting for output slot

	logic [3:0]      state_q;
	logic [1:0]      cnt_q;
	logic [AW-1:0]   ca_q, cb_q, cc_q, ridx_addr_q, corner_addr;
	logic [IDX_W-1:0] ridx_q;
	logic            bad_q;
	logic [PW-1:0]   pa_q, pb_q;

	logic            accept, is_load, is_tri, is_read;
	logic            vi_ok, tri_ok;

	logic            pos_we;
	logic [AW-1:0]   pos_raddr;
	logic [PW-1:0]   pos_wdata, pos_rdata;

	logic            sum_we;
	logic [AW-1:0]   sum_waddr, sum_raddr;
	logic [SW-1:0]   sum_wdata, sum_rdata;
	logic signed [SUM_W-1:0] rsx, rsy, rsz;

	logic            cross_start, cross_done;
	logic signed [NW-1:0] nx, ny, nz;

	logic            norm_start, norm_done, norm_degen;
	logic signed [UNIT_W-1:0] norm_ux, norm_uy, norm_uz;

	logic            out_free, out_load;
	logic            res_valid_q;
	result_t         res_q;

	function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
		return 32'(idx) < MAX_VERTICES;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] s,
		input logic signed [NW-1:0]    d
	);
		logic signed [ADD_W-1:0] t;
		t = ADD_W'(s) + ADD_W'(d);
		if (t > ADD_W'(SUM_MAX)) return SUM_MAX;
		if (t < ADD_W'(SUM_MIN)) return SUM_MIN;
		return SUM_W'(t);
	endfunction

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign is_load    = (item.operation == OP_LOAD);
	assign is_tri     = (item.operation == OP_TRI);
	assign is_read    = (item.operation == OP_READ);
	assign vi_ok      = idx_ok(item.vertex_index);
	assign tri_ok     = idx_ok(item.corner_a) && idx_ok(item.corner_b) &&
	                    idx_ok(item.corner_c);

	// ---- position memory: written by load, read a, b, c for a triangle ----
	assign pos_we    = accept && is_load && vi_ok;
	assign pos_wdata = {COORD_BITS'(item.pos_z), COORD_BITS'(item.pos_y),
	                    COORD_BITS'(item.pos_x)};

	always_comb begin
		case (cnt_q)
			2'd0: pos_raddr = ca_q;
			2'd1: pos_raddr = cb_q;
			default: pos_raddr = cc_q;
		endcase
	end

	vna_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_VERTICES)
	) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (AW'(item.vertex_index)),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// ---- normal-sum memory: cleared by load, accumulated b, c, a ----
	always_comb begin
		case (cnt_q)
			2'd0: corner_addr = cb_q;
			2'd1: corner_addr = cc_q;
			default: corner_addr = ca_q;
		endcase
	end

	assign rsx = sum_rdata[SUM_W-1:0];
	assign rsy = sum_rdata[2*SUM_W-1:SUM_W];
	assign rsz = sum_rdata[3*SUM_W-1:2*SUM_W];

	// each RMW writes before the next read issues, so a repeated corner
	// sees its own earlier update without forwarding
	assign sum_we    = (accept && is_load && vi_ok) || (state_q == S_TWR);
	assign sum_waddr = (state_q == S_TWR) ? corner_addr : AW'(item.vertex_index);
	assign sum_wdata = (state_q == S_TWR) ?
	                   {sat_add(rsz, nz), sat_add(rsy, ny), sat_add(rsx, nx)} : '0;
	assign sum_raddr = (state_q == S_RRD) ? ridx_addr_q : corner_addr;

	vna_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_VERTICES)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// ---- cross product: pc comes straight off the read port ----
	assign cross_start = (state_q == S_TPOS) && (cnt_q == 2'd3);

	vna_cross #(
		.COORD_BITS(COORD_BITS)
	) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cross_start),
		.pos_a  (pa_q),
		.pos_b  (pb_q),
		.pos_c  (pos_rdata),
		.done   (cross_done),
		.norm_x (nx),
		.norm_y (ny),
		.norm_z (nz)
	);

	// ---- normaliser ----
	assign norm_start = (state_q == S_RSUM);

	vna_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (norm_start),
		.sum_x      (rsx),
		.sum_y      (rsy),
		.sum_z      (rsz),
		.done       (norm_done),
		.unit_x     (norm_ux),
		.unit_y     (norm_uy),
		.unit_z     (norm_uz),
		.degenerate (norm_degen)
	);

	// ---- output slot: decouples the read result from downstream stalls ----
	assign out_free = !res_valid_q || result_ready;
	assign out_load = out_free &&
	                  (((state_q == S_NORM) && norm_done) || (state_q == S_OUT));

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (is_tri && tri_ok) begin
							state_q <= S_TPOS;
						end else if (is_read) begin
							state_q <= vi_ok ? S_RRD : S_OUT;
						end
					end
				end
				S_TPOS: begin
					if (cnt_q == 2'd3) begin
						state_q <= S_TMUL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				S_TMUL: if (cross_done) state_q <= S_TRD;
				S_TRD:  state_q <= S_TWR;
				S_TWR: begin
					if (cnt_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q   <= cnt_q + 2'd1;
						state_q <= S_TRD;
					end
				end
				S_RRD:  state_q <= S_RSUM;
				S_RSUM: state_q <= S_NORM;
				S_NORM: begin
					if (norm_done) begin
						state_q <= out_free ? S_IDLE : S_OUT;
					end
				end
				S_OUT:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ca_q        <= AW'(item.corner_a);
			cb_q        <= AW'(item.corner_b);
			cc_q        <= AW'(item.corner_c);
			ridx_q      <= item.vertex_index;
			ridx_addr_q <= AW'(item.vertex_index);
			bad_q       <= !vi_ok;
		end
		if (state_q == S_TPOS) begin
			if (cnt_q == 2'd1) pa_q <= pos_rdata;
			if (cnt_q == 2'd2) pb_q <= pos_rdata;
		end
		if (out_load) begin
			res_q.normal_vertex <= ridx_q;
			res_q.unit_x        <= bad_q ? '0 : norm_ux;
			res_q.unit_y        <= bad_q ? '0 : norm_uy;
			res_q.unit_z        <= bad_q ? '0 : norm_uz;
			res_q.degenerate    <= bad_q || norm_degen;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;
endmodule

@@ src/vna_checker.sv @@
// ----------------------------------------------------------------------------
// vna_checker: port-level checks for the vertex normal accumulator
// Watches the beat channels only; bound to the top level below.
// ----------------------------------------------------------------------------
module vna_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input vna_pkg::item_t    item,
	input logic              result_valid,
	input logic              result_ready,
	input vna_pkg::result_t  result
);
	import vna_pkg::*;

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// degenerate result carries a zero vector
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
		result.unit_x == '0 && result.unit_y == '0 && result.unit_z == '0)
		else $error("degenerate result with non-zero units");

	// unit components never exceed one in Q1.14
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		result.unit_x <= UNIT_ONE && result.unit_x >= -UNIT_ONE &&
		result.unit_y <= UNIT_ONE && result.unit_y >= -UNIT_ONE &&
		result.unit_z <= UNIT_ONE && result.unit_z >= -UNIT_ONE)
		else $error("unit component out of range");

	// input is not ready in the cycle after a read beat is taken
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.operation == OP_READ |=> !item_ready)
		else $error("input taken straight after a read beat");
endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (.*);

@@ sim/vertex_normal_accumulator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_unit_tb: self-checking bench for the normal unit
// Drives load, triangle and read beats with random gaps and result stalls,
// predicts every normal in a scoreboard class and checks each result beat.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_unit_tb;
	import vna_pkg::*;

	localparam int NVERT = MAX_VERTICES_DEF;
	localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam int RANDOM_ITEMS = 760;
	localparam int SAT_TRIS = 48;  // repeated full-size faces, large sums

	// Mirrors position and sum memories; queues the normals still owed.
	class normal_scoreboard;
		longint pos_tab[NVERT][3];
		longint sum_tab[NVERT][3];
		result_t owed_normals[$];
		int errors;

		function longint sat_add(longint s, longint d);
			longint r;
			r = s + d;
			if (r > SUM_HI) return SUM_HI;
			if (r < SUM_LO) return SUM_LO;
			return r;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function result_t normalise(logic [IDX_W-1:0] vi);
			result_t res;
			longint s[3];
			longint unsigned r[3];
			longint unsigned mmax, sq, len, q;
			logic [UNIT_W-1:0] qv;
			res = '0;
			res.normal_vertex = vi;
			for (int k = 0; k < 3; k++) begin
				s[k] = sum_tab[vi][k];
				r[k] = (s[k] < 0) ? longint'(-s[k]) : longint'(s[k]);
			end
			mmax = r[0];
			if (r[1] > mmax) mmax = r[1];
			if (r[2] > mmax) mmax = r[2];
			if (mmax == 0) begin
				res.degenerate = 1'b1;
				return res;
			end
			// range shift into [2^30, 2^31)
			while (mmax >= (64'd1 << 31)) begin
				for (int k = 0; k < 3; k++) r[k] = r[k] >> 1;
				mmax = mmax >> 1;
			end
			while (mmax < (64'd1 << 30)) begin
				for (int k = 0; k < 3; k++) r[k] = r[k] << 1;
				mmax = mmax << 1;
			end
			sq = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
			len = int_sqrt(sq);
			for (int k = 0; k < 3; k++) begin
				q = (r[k] * 64'd32768 + len) / (64'd2 * len);
				qv = q[UNIT_W-1:0];
				if (s[k] < 0) qv = -qv;
				case (k)
					0: res.unit_x = qv;
					1: res.unit_y = qv;
					default: res.unit_z = qv;
				endcase
			end
			return res;
		endfunction

		function void note_item(item_t it);
			longint u[3], v[3], n[3];
			int cs[3];
			case (it.operation)
				OP_LOAD: begin
					pos_tab[it.vertex_index][0] = longint'(it.pos_x);
					pos_tab[it.vertex_index][1] = longint'(it.pos_y);
					pos_tab[it.vertex_index][2] = longint'(it.pos_z);
					for (int k = 0; k < 3; k++) sum_tab[it.vertex_index][k] = 0;
				end
				OP_TRI: begin
					for (int k = 0; k < 3; k++) begin
						u[k] = pos_tab[it.corner_a][k] - pos_tab[it.corner_b][k];
						v[k] = pos_tab[it.corner_b][k] - pos_tab[it.corner_c][k];
					end
					n[0] = u[1] * v[2] - u[2] * v[1];
					n[1] = u[2] * v[0] - u[0] * v[2];
					n[2] = u[0] * v[1] - u[1] * v[0];
					cs[0] = it.corner_a;
					cs[1] = it.corner_b;
					cs[2] = it.corner_c;
					// once per corner slot, so a repeated corner gets it twice
					for (int c = 0; c < 3; c++)
						for (int k = 0; k < 3; k++)
							sum_tab[cs[c]][k] = sat_add(sum_tab[cs[c]][k], n[k]);
				end
				OP_READ: owed_normals.insert(owed_normals.size(),
					normalise(it.vertex_index));
				default: ;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (owed_normals.size() == 0) begin
				$error("result beat with nothing outstanding: vertex %0d", got.normal_vertex);
				errors++;
				return;
			end
			exp_r = owed_normals.pop_front();
			if (got.normal_vertex !== exp_r.normal_vertex) begin
				$error("normal_vertex: expected %0d, got %0d",
					exp_r.normal_vertex, got.normal_vertex);
				errors++;
			end
			if (got.unit_x !== exp_r.unit_x) begin
				$error("unit_x: expected %0d, got %0d", exp_r.unit_x, got.unit_x);
				errors++;
			end
			if (got.unit_y !== exp_r.unit_y) begin
				$error("unit_y: expected %0d, got %0d", exp_r.unit_y, got.unit_y);
				errors++;
			end
			if (got.unit_z !== exp_r.unit_z) begin
				$error("unit_z: expected %0d, got %0d", exp_r.unit_z, got.unit_z);
				errors++;
			end
			if (got.degenerate !== exp_r.degenerate) begin
				$error("degenerate: expected %0d, got %0d",
					exp_r.degenerate, got.degenerate);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	normal_scoreboard sb;
	int loaded_q[$];
	bit is_loaded[NVERT];
	bit stim_done;

	vertex_normal_accumulator_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// generous fixed bound, well past the directed and random parts
	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// One beat onto the input channel. Valid stays high straight into the
	// next beat when the gap is zero, so it is never dropped and re-raised.
	task automatic send_beat(item_t it, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
		if (it.operation == OP_LOAD && !is_loaded[it.vertex_index]) begin
			is_loaded[it.vertex_index] = 1'b1;
			loaded_q.insert(loaded_q.size(), it.vertex_index);
		end
	endtask

	function automatic item_t noise_beat();
		return item_t'($bits(item_t)'({$urandom, $urandom, $urandom}));
	endfunction

	function automatic logic signed [FIELD_W-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 2))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					default: return '0;
				endcase
			end
			1: return FIELD_W'($signed($urandom_range(0, 1023)) - 512);
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	function automatic item_t load_beat(int vi, int x, int y, int z);
		item_t it;
		it = noise_beat();
		it.operation    = OP_LOAD;
		it.vertex_index = IDX_W'(vi);
		it.pos_x        = FIELD_W'(x);
		it.pos_y        = FIELD_W'(y);
		it.pos_z        = FIELD_W'(z);
		return it;
	endfunction

	function automatic item_t tri_beat(int a, int b, int c);
		item_t it;
		it = noise_beat();
		it.operation = OP_TRI;
		it.corner_a  = IDX_W'(a);
		it.corner_b  = IDX_W'(b);
		it.corner_c  = IDX_W'(c);
		return it;
	endfunction

	function automatic item_t read_beat(int vi);
		item_t it;
		it = noise_beat();
		it.operation    = OP_READ;
		it.vertex_index = IDX_W'(vi);
		return it;
	endfunction

	function automatic int any_loaded();
		return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
	endfunction

	// stimulus
	initial begin
		item_t it;
		int sent, wait_cnt;
		sb = new();
		stim_done  = 1'b0;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of the index and coordinate ranges
		send_beat(load_beat(0, 32767, 32767, 32767), 0);
		send_beat(load_beat(1023, -32768, -32768, -32768), 0);
		send_beat(load_beat(512, 32767, -32768, 0), 0);
		send_beat(load_beat(511, 0, 256, -256), 0);
		send_beat(read_beat(0), 0);              // freshly loaded: zero sum
		send_beat(tri_beat(0, 1023, 512), 0);
		send_beat(read_beat(0), 0);
		send_beat(read_beat(1023), 0);
		send_beat(read_beat(512), 0);
		send_beat(tri_beat(511, 511, 0), 0);     // repeated corner, zero face
		send_beat(tri_beat(512, 512, 512), 0);
		send_beat(read_beat(511), 0);
		send_beat(tri_beat(1023, 511, 0), 0);
		send_beat(tri_beat(0, 511, 1023), 0);    // opposite winding cancels
		send_beat(read_beat(511), 0);
		it = noise_beat();
		it.operation = 2'd3;                     // unused code, no result
		send_beat(it, 0);
		send_beat(load_beat(0, 1, 0, 0), 0);     // reload clears the sum
		send_beat(read_beat(0), 0);

		// large sums: one full-size face summed back to back
		send_beat(load_beat(100, 0, 32767, -32768), 0);
		send_beat(load_beat(101, 0, -32768, 32767), 0);
		send_beat(load_beat(102, 0, 32767, 32767), 0);
		for (int i = 0; i < SAT_TRIS; i++)
			send_beat(tri_beat(100, 101, 102), 1);
		send_beat(read_beat(100), 0);
		send_beat(read_beat(101), 0);
		send_beat(tri_beat(102, 101, 100), 0);   // reversed winding backs off
		send_beat(read_beat(102), 0);

		// random part: mostly valid meshes on loaded vertices
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4:
					send_beat(load_beat($urandom_range(0, NVERT - 1), pick_coord(),
						pick_coord(), pick_coord()), 0);
				5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15:
					send_beat(tri_beat(any_loaded(), any_loaded(), any_loaded()), 0);
				16, 17, 18:
					send_beat(read_beat(any_loaded()), 0);
				default: begin
					it = noise_beat();
					it.operation = 2'd3;
					send_beat(it, 0);
					sent--;                        // ignored beats do not count
				end
			endcase
			sent++;
		end
		item_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// result side: random stalls, ready held high across zero-stall beats
	initial begin
		int stall;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 3);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			sb.check_result(result);
		end
	end

	// end of run: drain, then keep watching for stray beats before the verdict
	initial begin
		wait (stim_done);
		while (sb.owed_normals.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.owed_normals.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/vna_pkg.sv
src/vna_ram.sv
src/vna_cross.sv
src/vna_norm.sv
src/vertex_normal_accumulator_unit.sv
src/vna_checker.sv
sim/vertex_normal_accumulator_unit_tb.sv
